>>> rtl/lr_pkg.sv
package lr_pkg;

    // Meaning of the input tuser bit.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    // Octant cases chosen at load time.
    localparam logic [1:0] OCT_SHALLOW_UP = 2'd0;
    localparam logic [1:0] OCT_SHALLOW_DN = 2'd1;
    localparam logic [1:0] OCT_STEEP_UP   = 2'd2;
    localparam logic [1:0] OCT_STEEP_DN   = 2'd3;

    localparam int COLOR_BITS = 24;

endpackage

>>> rtl/line_rasterizer.sv
// Midpoint line rasterizer that hands out one pixel per step request.
// Input stream (s_axis): tuser is the item kind. A load beat carries both
// endpoints in tdata and starts a new line, abandoning any line in progress;
// a step beat asks for the next pixel of the current line.
// Output stream (m_axis): exactly one beat per input beat. A step on an active
// line returns a pixel with tuser (pixel valid) set; the final endpoint pixel
// also raises tlast. Load beats, and steps when no line is active, return a
// beat with every field zero.
// Configuration: i_cfg_wr_en writes the 24-bit draw color, which is copied
// into every pixel as it is produced. Write it only while the block is idle.
// The result of an accepted beat is offered on m_axis from the next cycle
// on. Throughput is one beat per clock while the receiver does not stall,
// set by the error-term add and compare between the line state and the
// output register. While the receiver stalls, the output register holds its
// beat and s_axis_tready drops; it rises again in the same cycle the held
// beat is taken. After reset no line is active and the color is zero.
module line_rasterizer #(
    parameter int COORD_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_wr_en,
    input  logic [23:0]            i_cfg_wr_data,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // start_x, start_y, end_x, end_y from bit 0 up, zero padding above.
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // kind: 0 loads a line, 1 steps to the next pixel.
    input  logic                   s_axis_tuser,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // pixel_x, pixel_y, pixel_color from bit 0 up, zero padding above.
    output logic [((2*COORD_BITS+24+7)/8)*8-1:0] m_axis_tdata,
    // pixel_valid.
    output logic                   m_axis_tuser,
    // last_pixel.
    output logic                   m_axis_tlast
);

    localparam int CB  = COORD_BITS;
    localparam int IW  = CB + 2;
    localparam int EW  = CB + 4;
    localparam int OW  = ((2*CB+24+7)/8)*8;

    // Line phase codes.
    localparam logic PHASE_IDLE = 1'b0;
    localparam logic PHASE_DRAW = 1'b1;

    logic [lr_pkg::COLOR_BITS-1:0] r_color;

    // Line state.
    logic                 r_phase,  n_phase;
    logic signed [CB-1:0] r_cur_x,  n_cur_x;
    logic signed [CB-1:0] r_cur_y,  n_cur_y;
    logic signed [CB-1:0] r_stop_x, n_stop_x;
    logic signed [CB-1:0] r_stop_y, n_stop_y;
    logic signed [EW-1:0] r_error,  n_error;
    logic signed [IW-1:0] r_incr_a, n_incr_a;
    logic signed [IW-1:0] r_incr_b, n_incr_b;
    logic [1:0]           r_octant, n_octant;

    // Output register.
    logic                          r_out_valid;
    logic signed [CB-1:0]          r_out_x,     n_out_x;
    logic signed [CB-1:0]          r_out_y,     n_out_y;
    logic [lr_pkg::COLOR_BITS-1:0] r_out_color, n_out_color;
    logic                          r_out_pv,    n_out_pv;
    logic                          r_out_last,  n_out_last;

    logic                 in_beat;

    // Load setup results.
    logic signed [CB-1:0] ld_cur_x, ld_cur_y, ld_stop_x, ld_stop_y;
    logic signed [EW-1:0] ld_error;
    logic signed [IW-1:0] ld_incr_a, ld_incr_b;
    logic [1:0]           ld_octant;

    // Step datapath.
    logic                 more;
    logic                 minor_cond;
    logic signed [EW-1:0] ia_e, ib_e;
    logic signed [EW-1:0] add_major, add_minor;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    lr_setup #(
        .COORD_BITS (CB)
    ) u_setup (
        .i_start_x (s_axis_tdata[CB-1:0]),
        .i_start_y (s_axis_tdata[2*CB-1:CB]),
        .i_end_x   (s_axis_tdata[3*CB-1:2*CB]),
        .i_end_y   (s_axis_tdata[4*CB-1:3*CB]),
        .o_cur_x   (ld_cur_x),
        .o_cur_y   (ld_cur_y),
        .o_stop_x  (ld_stop_x),
        .o_stop_y  (ld_stop_y),
        .o_error   (ld_error),
        .o_incr_a  (ld_incr_a),
        .o_incr_b  (ld_incr_b),
        .o_octant  (ld_octant)
    );

    assign ia_e = {{(EW-IW){r_incr_a[IW-1]}}, r_incr_a};
    assign ib_e = {{(EW-IW){r_incr_b[IW-1]}}, r_incr_b};

    // Per octant: whether the line goes on, the error change along the major
    // axis, and the extra change when the minor axis also moves.
    always_comb begin
        case (r_octant)
            lr_pkg::OCT_SHALLOW_UP: begin
                more       = r_cur_x < r_stop_x;
                minor_cond = r_error > 0;
                add_major  = ia_e;
                add_minor  = ib_e;
            end
            lr_pkg::OCT_SHALLOW_DN: begin
                more       = r_cur_x < r_stop_x;
                minor_cond = r_error < 0;
                add_major  = ia_e;
                add_minor  = -ib_e;
            end
            lr_pkg::OCT_STEEP_UP: begin
                more       = r_cur_y < r_stop_y;
                minor_cond = r_error < 0;
                add_major  = ib_e;
                add_minor  = ia_e;
            end
            default: begin
                more       = r_cur_y > r_stop_y;
                minor_cond = r_error > 0;
                add_major  = -ib_e;
                add_minor  = ia_e;
            end
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_stop_x    = r_stop_x;
        n_stop_y    = r_stop_y;
        n_error     = r_error;
        n_incr_a    = r_incr_a;
        n_incr_b    = r_incr_b;
        n_octant    = r_octant;
        n_out_x     = '0;
        n_out_y     = '0;
        n_out_color = '0;
        n_out_pv    = 1'b0;
        n_out_last  = 1'b0;

        if (s_axis_tuser == lr_pkg::KIND_LOAD) begin
            n_phase  = PHASE_DRAW;
            n_cur_x  = ld_cur_x;
            n_cur_y  = ld_cur_y;
            n_stop_x = ld_stop_x;
            n_stop_y = ld_stop_y;
            n_error  = ld_error;
            n_incr_a = ld_incr_a;
            n_incr_b = ld_incr_b;
            n_octant = ld_octant;
        end else if (r_phase == PHASE_DRAW) begin
            n_out_color = r_color;
            n_out_pv    = 1'b1;
            if (!more) begin
                // End point reached: emit it exactly and go idle.
                n_out_x    = r_stop_x;
                n_out_y    = r_stop_y;
                n_out_last = 1'b1;
                n_phase    = PHASE_IDLE;
            end else begin
                n_out_x = r_cur_x;
                n_out_y = r_cur_y;
                n_error = r_error + add_major + (minor_cond ? add_minor : '0);
                case (r_octant)
                    lr_pkg::OCT_SHALLOW_UP: begin
                        n_cur_x = r_cur_x + CB'(1);
                        n_cur_y = minor_cond ? r_cur_y + CB'(1) : r_cur_y;
                    end
                    lr_pkg::OCT_SHALLOW_DN: begin
                        n_cur_x = r_cur_x + CB'(1);
                        n_cur_y = minor_cond ? r_cur_y - CB'(1) : r_cur_y;
                    end
                    lr_pkg::OCT_STEEP_UP: begin
                        n_cur_y = r_cur_y + CB'(1);
                        n_cur_x = minor_cond ? r_cur_x + CB'(1) : r_cur_x;
                    end
                    default: begin
                        n_cur_y = r_cur_y - CB'(1);
                        n_cur_x = minor_cond ? r_cur_x + CB'(1) : r_cur_x;
                    end
                endcase
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color     <= '0;
            r_phase     <= PHASE_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_color <= i_cfg_wr_data;
            end
            if (in_beat) begin
                r_phase     <= n_phase;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Line state and output payload.
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_stop_x    <= n_stop_x;
            r_stop_y    <= n_stop_y;
            r_error     <= n_error;
            r_incr_a    <= n_incr_a;
            r_incr_b    <= n_incr_b;
            r_octant    <= n_octant;
            r_out_x     <= n_out_x;
            r_out_y     <= n_out_y;
            r_out_color <= n_out_color;
            r_out_pv    <= n_out_pv;
            r_out_last  <= n_out_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OW'({r_out_color, r_out_y, r_out_x});
    assign m_axis_tuser  = r_out_pv;
    assign m_axis_tlast  = r_out_last;

endmodule

>>> rtl/lr_setup.sv
module lr_setup #(
    parameter int COORD_BITS = 12
) (
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic signed [COORD_BITS-1:0] o_cur_x,
    output logic signed [COORD_BITS-1:0] o_cur_y,
    output logic signed [COORD_BITS-1:0] o_stop_x,
    output logic signed [COORD_BITS-1:0] o_stop_y,
    output logic signed [COORD_BITS+3:0] o_error,
    output logic signed [COORD_BITS+1:0] o_incr_a,
    output logic signed [COORD_BITS+1:0] o_incr_b,
    output logic [1:0]                   o_octant
);

    localparam int DW = COORD_BITS + 1;
    localparam int EW = COORD_BITS + 4;

    logic                  swap;
    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dy;
    logic signed [DW-1:0]  ady;
    logic signed [EW-1:0]  dx_e;
    logic signed [EW-1:0]  dy_e;
    logic                  steep;
    logic                  rising;

    // Order the endpoints so that x never decreases along the line.
    assign swap     = i_start_x > i_end_x;
    assign o_cur_x  = swap ? i_end_x   : i_start_x;
    assign o_cur_y  = swap ? i_end_y   : i_start_y;
    assign o_stop_x = swap ? i_start_x : i_end_x;
    assign o_stop_y = swap ? i_start_y : i_end_y;

    assign dx = {o_stop_x[COORD_BITS-1], o_stop_x} - {o_cur_x[COORD_BITS-1], o_cur_x};
    assign dy = {o_stop_y[COORD_BITS-1], o_stop_y} - {o_cur_y[COORD_BITS-1], o_cur_y};
    assign ady = dy[DW-1] ? -dy : dy;

    assign dx_e = {{(EW-DW){dx[DW-1]}}, dx};
    assign dy_e = {{(EW-DW){dy[DW-1]}}, dy};

    assign o_incr_a = {dy, 1'b0};
    assign o_incr_b = -{dx, 1'b0};

    // A slope of exactly one stays with the shallow cases.
    assign steep  = ady > dx;
    assign rising = dy > 0;

    always_comb begin
        if (!steep) begin
            if (rising) begin
                o_octant = lr_pkg::OCT_SHALLOW_UP;
                o_error  = dy_e + dy_e - dx_e;
            end else begin
                o_octant = lr_pkg::OCT_SHALLOW_DN;
                o_error  = dy_e + dy_e + dx_e;
            end
        end else begin
            if (rising) begin
                o_octant = lr_pkg::OCT_STEEP_UP;
                o_error  = dy_e - dx_e - dx_e;
            end else begin
                o_octant = lr_pkg::OCT_STEEP_DN;
                o_error  = dy_e + dx_e + dx_e;
            end
        end
    end

endmodule

>>> dv/line_rasterizer_test.sv
module line_rasterizer_test;

    localparam int CW            = 12;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_OFF_BEAT = 250;   // input beats seen before the long output stall
    localparam int HOLD_OFF_LEN  = 80;    // cycles of that stall

    // One expected output beat, unpacked into its fields.
    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [23:0]          color;
        logic                 valid;
        logic                 last;
    } t_pixel;

    // The scoreboard carries its own copy of the line state. Every accepted input
    // beat advances that state and queues the one pixel beat it must produce.
    class t_pixel_scoreboard;
        t_pixel      pending_pixels[$];
        int          errors;
        logic [23:0] color;
        bit          drawing;
        logic [1:0]  octant;
        int          cur_x, cur_y, stop_x, stop_y;
        int          err_acc, step_a, step_b;

        function new();
            errors  = 0;
            color   = '0;
            drawing = 1'b0;
            octant  = lr_pkg::OCT_SHALLOW_UP;
        endfunction

        task report(input string msg);
            $display("line_rasterizer_test: mismatch: %s", msg);
            errors++;
        endtask

        function int pending();
            return pending_pixels.size();
        endfunction

        // Sets up the midpoint walk. The endpoints are ordered so that x never
        // decreases; then the slope and the sign of dy pick the octant case. A
        // slope of exactly one counts as shallow.
        function void start_line(input int x0, input int y0, input int x1, input int y1);
            int swap_v, dx, dy, ady;
            if (x0 > x1) begin
                swap_v = x0; x0 = x1; x1 = swap_v;
                swap_v = y0; y0 = y1; y1 = swap_v;
            end
            cur_x  = x0;
            cur_y  = y0;
            stop_x = x1;
            stop_y = y1;
            dx     = x1 - x0;
            dy     = y1 - y0;
            step_a = 2 * dy;
            step_b = -2 * dx;
            ady    = (dy < 0) ? -dy : dy;
            if (dx >= ady) begin
                if (step_a > 0) begin
                    octant  = lr_pkg::OCT_SHALLOW_UP;
                    err_acc = step_a + step_b / 2;
                end else begin
                    octant  = lr_pkg::OCT_SHALLOW_DN;
                    err_acc = step_a - step_b / 2;
                end
            end else begin
                if (step_a > 0) begin
                    octant  = lr_pkg::OCT_STEEP_UP;
                    err_acc = step_a / 2 + step_b;
                end else begin
                    octant  = lr_pkg::OCT_STEEP_DN;
                    err_acc = step_a / 2 - step_b;
                end
            end
            drawing = 1'b1;
        endfunction

        // Called once per accepted input beat.
        function void plot_step(input logic kind,
                                input logic signed [CW-1:0] sx, input logic signed [CW-1:0] sy,
                                input logic signed [CW-1:0] ex, input logic signed [CW-1:0] ey);
            t_pixel px;
            bit     more;
            px = '{x: '0, y: '0, color: '0, valid: 1'b0, last: 1'b0};
            if (kind == lr_pkg::KIND_LOAD) begin
                // A load abandons any line in progress and answers with an empty beat.
                start_line(int'(sx), int'(sy), int'(ex), int'(ey));
            end else if (drawing) begin
                case (octant)
                    lr_pkg::OCT_SHALLOW_UP, lr_pkg::OCT_SHALLOW_DN: more = cur_x < stop_x;
                    lr_pkg::OCT_STEEP_UP:                           more = cur_y < stop_y;
                    default:                                        more = cur_y > stop_y;
                endcase
                px.color = color;
                px.valid = 1'b1;
                if (!more) begin
                    // The end pixel is emitted exactly and closes the line.
                    px.x    = stop_x[CW-1:0];
                    px.y    = stop_y[CW-1:0];
                    px.last = 1'b1;
                    drawing = 1'b0;
                end else begin
                    px.x = cur_x[CW-1:0];
                    px.y = cur_y[CW-1:0];
                    case (octant)
                        lr_pkg::OCT_SHALLOW_UP: begin
                            if (err_acc > 0) begin
                                cur_y++;
                                err_acc += step_b;
                            end
                            cur_x++;
                            err_acc += step_a;
                        end
                        lr_pkg::OCT_SHALLOW_DN: begin
                            if (err_acc < 0) begin
                                cur_y--;
                                err_acc -= step_b;
                            end
                            cur_x++;
                            err_acc += step_a;
                        end
                        lr_pkg::OCT_STEEP_UP: begin
                            if (err_acc < 0) begin
                                cur_x++;
                                err_acc += step_a;
                            end
                            cur_y++;
                            err_acc += step_b;
                        end
                        default: begin
                            if (err_acc > 0) begin
                                cur_x++;
                                err_acc += step_a;
                            end
                            cur_y--;
                            err_acc -= step_b;
                        end
                    endcase
                end
            end
            // A step with no active line falls through with the empty beat.
            pending_pixels.push_back(px);
        endfunction

        task check_pixel(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                         input logic [23:0] c, input logic valid, input logic last);
            t_pixel want;
            if (pending_pixels.size() == 0) begin
                report($sformatf("output beat with nothing expected (x=%0d y=%0d)", x, y));
            end else begin
                want = pending_pixels.pop_front();
                if (x !== want.x)
                    report($sformatf("pixel_x %0d, expected %0d", x, want.x));
                if (y !== want.y)
                    report($sformatf("pixel_y %0d, expected %0d", y, want.y));
                if (c !== want.color)
                    report($sformatf("pixel_color %06h, expected %06h", c, want.color));
                if (valid !== want.valid)
                    report($sformatf("pixel_valid %b, expected %b", valid, want.valid));
                if (last !== want.last)
                    report($sformatf("last_pixel %b, expected %b", last, want.last));
            end
        endtask
    endclass

    logic          i_clk         = 1'b0;
    logic          i_rst_n       = 1'b0;
    logic          i_cfg_wr_en   = 1'b0;
    logic [23:0]   i_cfg_wr_data = '0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [47:0]   s_axis_tdata  = '0;   // start_x, start_y, end_x, end_y from bit 0 up
    logic          s_axis_tuser  = 1'b0; // kind
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [47:0]   m_axis_tdata;         // pixel_x, pixel_y, pixel_color from bit 0 up
    logic          m_axis_tuser;         // pixel_valid
    logic          m_axis_tlast;         // last_pixel

    t_pixel_scoreboard sb = new();

    int beats_in   = 0;    // input beats accepted so far
    int cycles     = 0;
    int hold_left  = 0;
    bit held_once  = 1'b0;
    bit steady     = 1'b0; // while set, neither side idles at random

    line_rasterizer #(.COORD_BITS(CW)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 0;
    end

    // Watchdog. The slowest correct run stays far below this limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("line_rasterizer_test: done, errors");
            $finish;
        end
    end

    // Receiver. It stalls at random a third of the time, never while the steady
    // flag is up, and once holds off for a long stretch so that the output
    // register fills and the block drops s_axis_tready against a busy sender.
    always @(posedge i_clk) begin
        if (!held_once && beats_in >= HOLD_OFF_BEAT) begin
            held_once = 1'b1;
            hold_left = HOLD_OFF_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 33);
        end
    end

    // Output monitor. Values read here are those that stood before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_pixel(m_axis_tdata[CW-1:0], m_axis_tdata[2*CW-1:CW],
                           m_axis_tdata[2*CW+23:2*CW], m_axis_tuser, m_axis_tlast);
    end

    function automatic int clamp_coord(input int v);
        if (v > 2047)
            return 2047;
        if (v < -2048)
            return -2048;
        return v;
    endfunction

    // Offers one beat, possibly after a short gap, and returns at the edge that
    // accepts it. tvalid stays high across back-to-back beats.
    task automatic send_item(input logic kind,
                             input logic signed [CW-1:0] sx, input logic signed [CW-1:0] sy,
                             input logic signed [CW-1:0] ex, input logic signed [CW-1:0] ey);
        if (!steady && $urandom_range(0, 99) < 33) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {ey, ex, sy, sx};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.plot_step(kind, sx, sy, ex, ey);
        beats_in++;
    endtask

    // Step beats carry random coordinates, which the block must ignore.
    task automatic send_step();
        send_item(lr_pkg::KIND_STEP, CW'($urandom), CW'($urandom), CW'($urandom),
                  CW'($urandom));
    endtask

    task automatic send_load(input int sx, input int sy, input int ex, input int ey);
        send_item(lr_pkg::KIND_LOAD, CW'(sx), CW'(sy), CW'(ex), CW'(ey));
    endtask

    // Stops offering and waits until every expected pixel has come out, then
    // lets the single register stage settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_color(input logic [23:0] value);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.color = value;
    endtask

    // Random traffic. Most of it is complete lines with random position and a
    // short random extent, walked to the end and sometimes one step past it.
    // Mixed in are lines cut short by a reload, loads with endpoints anywhere in
    // the coordinate range, and lone steps.
    task automatic draw_random_lines(input int n_beats);
        int goal, pick, bx, by, ex, ey, len, dx, dy, adx, ady, steps;
        goal = beats_in + n_beats;
        while (beats_in < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_step();
            end else if (pick < 15) begin
                send_load(int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 4095)) - 2048,
                          int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 4095)) - 2048);
                repeat ($urandom_range(0, 3)) send_step();
            end else begin
                bx  = int'($urandom_range(0, 4095)) - 2048;
                by  = int'($urandom_range(0, 4095)) - 2048;
                len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(13, 60))
                                                  : int'($urandom_range(0, 12));
                dx  = int'($urandom_range(0, 2 * len)) - len;
                if (pick < 30)
                    dy = $urandom_range(0, 1) ? dx : -dx;   // slope of exactly one
                else
                    dy = int'($urandom_range(0, 2 * len)) - len;
                ex  = clamp_coord(bx + dx);
                ey  = clamp_coord(by + dy);
                adx = (ex > bx) ? ex - bx : bx - ex;
                ady = (ey > by) ? ey - by : by - ey;
                steps = ((adx > ady) ? adx : ady) + 1 + int'($urandom_range(0, 1));
                if ($urandom_range(0, 9) == 0)
                    steps = $urandom_range(0, steps);
                send_load(bx, by, ex, ey);
                repeat (steps) send_step();
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, with the color still at its reset value.
        send_step();                           // no line loaded yet
        send_load(0, 0, 0, 0);                 // single point line
        send_step();
        send_step();                           // past the end
        send_load(-2048, 2047, 2047, -2048);   // full range, slope of minus one
        send_step();
        send_step();
        send_load(2047, -2048, -2048, 2047);   // reload mid-line, endpoints swapped
        send_step();
        send_load(0, 0, 3, 1);                 // shallow rising
        repeat (4) send_step();
        send_load(0, 0, -2, -3);               // swapped into steep rising
        repeat (4) send_step();
        send_load(0, 0, 1, -3);                // steep falling
        repeat (4) send_step();

        write_color(24'hFFFFFF);
        draw_random_lines(140);
        write_color(24'($urandom));
        steady = 1'b1;                         // one long stretch without random idling
        draw_random_lines(140);
        drain();
        steady = 1'b0;
        write_color(24'h000000);
        draw_random_lines(140);
        write_color(24'($urandom));
        draw_random_lines(140);
        write_color(24'h800001);
        draw_random_lines(140);

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("line_rasterizer_test: done, clean");
        end else begin
            $display("line_rasterizer_test: done, errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/lr_pkg.sv
rtl/lr_setup.sv
rtl/line_rasterizer.sv
dv/line_rasterizer_test.sv
